>>> sv/reed_solomon_parity_encoder_assert.svh
// assertion macros for the reed-solomon parity encoder
// expects clk and rst_n in the including scope, no other dependencies
`ifndef REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH
`define REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RSENC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RSENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rsenc_pkg.sv
// shared types, constants and gf(2^8) arithmetic for the rs parity encoder
// no dependencies
package rsenc_pkg;

  typedef logic [7:0] sym_t;
  typedef logic [5:0] pcount_t;

  // control to the remainder datapath: builder busy and config-write clear
  typedef struct packed {
    logic busy;
    logic clear;
  } gen_ctl_t;

  localparam sym_t FIELD_LOW_POLY = 8'h1d;
  localparam sym_t SYM_ZERO       = 8'h00;
  localparam sym_t SYM_ONE        = 8'h01;
  localparam sym_t ALPHA          = 8'h02;
  localparam int   RESET_PARITY   = 16;

  // multiply by alpha modulo x^8+x^4+x^3+x^2+1
  function automatic sym_t gf_xtime(sym_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? FIELD_LOW_POLY : SYM_ZERO);
  endfunction

  // full gf(2^8) product, shift-and-add over eight bits
  function automatic sym_t gf_mul(sym_t a, sym_t b);
    sym_t acc;
    sym_t p;
    acc = SYM_ZERO;
    p   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ p;
      p = gf_xtime(p);
    end
    return acc;
  endfunction

endpackage

>>> sv/rsenc_if.sv
// stream and config channel interfaces for the rs parity encoder
// depends on rsenc_pkg
interface rsenc_in_if import rsenc_pkg::*; ();
  logic valid;
  logic ready;
  sym_t data_byte;
  logic msg_last;
  modport source (output valid, output data_byte, output msg_last, input ready);
  modport sink   (input valid, input data_byte, input msg_last, output ready);
endinterface

interface rsenc_out_if import rsenc_pkg::*; ();
  logic valid;
  logic ready;
  sym_t parity_byte;
  logic parity_last;
  modport source (output valid, output parity_byte, output parity_last, input ready);
  modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface

interface rsenc_cfg_if import rsenc_pkg::*; ();
  logic    valid;
  logic    ready;
  pcount_t parity_count;
  modport source (output valid, output parity_count, input ready);
  modport sink   (input valid, input parity_count, output ready);
endinterface

>>> sv/reed_solomon_parity_encoder.sv
// systematic rs(gf(2^8)) parity encoder, poly 0x11d, n parity bytes per codeword
// throughput: one data beat per cycle outside rebuilds; a last beat waits for old parity to drain
// latency: first parity beat is valid the cycle after the last data beat leaves the input reg
// parity leaves the output buffer one beat per cycle while out ready, n beats per message
// reset (sync, active low): remainder cleared, generator rebuilt for 16 parity, in ready low
// while it builds; a parity_count write rebuilds likewise for the clamped count
`include "reed_solomon_parity_encoder_assert.svh"

module reed_solomon_parity_encoder
  import rsenc_pkg::*;
#(
  parameter int MAX_PARITY = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  rsenc_in_if.sink     in_if,
  rsenc_out_if.source  out_if,
  rsenc_cfg_if.sink    cfg_if
);

  localparam int NW = $clog2(MAX_PARITY + 1);

  logic                  gen_busy;
  logic                  cfg_wr;
  logic [NW-1:0]         n_parity;
  sym_t [MAX_PARITY:0]   gen_coef;
  sym_t [MAX_PARITY-1:0] rem_out;
  gen_ctl_t              ctl;
  logic                  load;
  logic                  buf_free;

  assign cfg_if.ready = !gen_busy;
  assign cfg_wr       = cfg_if.valid && cfg_if.ready;
  assign ctl.busy     = gen_busy;
  assign ctl.clear    = cfg_wr;

  // generator builder
  rsenc_gen #(.MAX_PARITY(MAX_PARITY)) u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cfg_value (cfg_if.parity_count),
    .busy      (gen_busy),
    .n_parity  (n_parity),
    .gen_coef  (gen_coef)
  );

  // remainder datapath
  rsenc_lfsr #(.MAX_PARITY(MAX_PARITY)) u_lfsr (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .ctl      (ctl),
    .gen_coef (gen_coef),
    .buf_free (buf_free),
    .load     (load),
    .rem_out  (rem_out)
  );

  // parity output buffer
  rsenc_obuf #(.MAX_PARITY(MAX_PARITY)) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (rem_out),
    .n_parity  (n_parity),
    .buf_free  (buf_free),
    .out_if    (out_if)
  );

  // checks
  `RSENC_ASSERT_NOW(a_no_beat_in_build, gen_busy, !in_if.ready, "input taken during rebuild")
  `RSENC_ASSERT_NEXT(a_cfg_starts_build, cfg_wr, gen_busy, "config write did not rebuild")
  `RSENC_ASSERT_NOW(a_load_when_free, load, buf_free, "parity overwrote undelivered beats")
  `RSENC_ASSERT_NEXT(a_parity_follows_last, load, out_if.valid, "no parity after last beat")

endmodule

>>> sv/rsenc_gen.sv
// generator polynomial builder: one (x + alpha^r) factor per cycle
// depends on rsenc_pkg
module rsenc_gen
  import rsenc_pkg::*;
#(
  parameter int MAX_PARITY = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr,
  input  pcount_t                              cfg_value,
  output logic                                 busy,
  output logic [$clog2(MAX_PARITY+1)-1:0]      n_parity,
  output sym_t [MAX_PARITY:0]                  gen_coef
);

  localparam int NW      = $clog2(MAX_PARITY + 1);
  localparam int CW      = 7;
  localparam int RESET_N = (RESET_PARITY > MAX_PARITY) ? MAX_PARITY : RESET_PARITY;

  logic [NW-1:0]         n_r, n_nxt;
  logic [NW-1:0]         step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  sym_t                  root_r, root_nxt;
  sym_t [MAX_PARITY:0]   gen_r, gen_nxt;
  sym_t [MAX_PARITY+1:0] gen_ext;
  logic [CW-1:0]         req;
  logic [NW-1:0]         req_n;

  // clamp the written count into 1..MAX_PARITY
  always_comb begin
    req = CW'(cfg_value);
    priority if (req == '0) begin
      req = CW'(1);
    end else if (req > CW'(MAX_PARITY)) begin
      req = CW'(MAX_PARITY);
    end
    req_n = req[NW-1:0];
  end

  assign gen_ext = {SYM_ZERO, gen_r};

  // rebuild: g <- g * (x + root), all coefficients in parallel
  always_comb begin
    n_nxt    = n_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    root_nxt = root_r;
    gen_nxt  = gen_r;
    if (cfg_wr) begin
      n_nxt    = req_n;
      step_nxt = '0;
      busy_nxt = 1'b1;
      root_nxt = ALPHA;
      for (int i = 0; i <= MAX_PARITY; i++) begin
        gen_nxt[i] = (NW'(i) == req_n) ? SYM_ONE : SYM_ZERO;
      end
    end else if (busy_r) begin
      for (int i = 0; i <= MAX_PARITY; i++) begin
        gen_nxt[i] = gen_ext[i+1] ^ gf_mul(root_r, gen_r[i]);
      end
      root_nxt = gf_xtime(root_r);
      step_nxt = step_r + 1'b1;
      if (step_nxt == n_r) busy_nxt = 1'b0;
    end
  end

  // reset starts a rebuild for the default parity count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= NW'(RESET_N);
      step_r <= '0;
      busy_r <= 1'b1;
      root_r <= ALPHA;
      for (int i = 0; i <= MAX_PARITY; i++) begin
        gen_r[i] <= (i == RESET_N) ? SYM_ONE : SYM_ZERO;
      end
    end else begin
      n_r    <= n_nxt;
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      root_r <= root_nxt;
      gen_r  <= gen_nxt;
    end
  end

  assign busy     = busy_r;
  assign n_parity = n_r;
  assign gen_coef = gen_r;

endmodule

>>> sv/rsenc_lfsr.sv
// input register and remainder lfsr, one data beat per cycle unless stalled
// depends on rsenc_pkg and rsenc_if
module rsenc_lfsr
  import rsenc_pkg::*;
#(
  parameter int MAX_PARITY = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rsenc_in_if.sink              in_if,
  input  gen_ctl_t              ctl,
  input  sym_t [MAX_PARITY:0]   gen_coef,
  input  logic                  buf_free,
  output logic                  load,
  output sym_t [MAX_PARITY-1:0] rem_out
);

  logic                  in_v_r, in_v_nxt;
  sym_t                  in_data_r;
  logic                  in_last_r;
  logic                  consume;
  logic                  in_acc;
  sym_t                  fb;
  sym_t [MAX_PARITY-1:0] rem_r, rem_nxt, rem_step;
  sym_t [MAX_PARITY:0]   rem_ext;

  // a held beat waits for a finished generator; a last beat also waits until
  // the parity buffer can take the remainder
  assign consume     = in_v_r && !ctl.busy && (!in_last_r || buf_free);
  assign in_if.ready = !ctl.busy && (!in_v_r || consume);
  assign in_acc      = in_if.valid && in_if.ready;

  // one lfsr division step; entries above the parity count stay zero
  assign fb      = in_data_r ^ rem_r[0];
  assign rem_ext = {SYM_ZERO, rem_r};
  always_comb begin
    for (int i = 0; i < MAX_PARITY; i++) begin
      rem_step[i] = rem_ext[i+1] ^ gf_mul(gen_coef[i+1], fb);
    end
  end

  // remainder update: cleared on config and after each message
  always_comb begin
    rem_nxt = rem_r;
    priority if (ctl.clear) begin
      rem_nxt = '0;
    end else if (consume) begin
      rem_nxt = in_last_r ? '0 : rem_step;
    end
    in_v_nxt = in_v_r;
    priority if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (consume) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_if.data_byte;
      in_last_r <= in_if.msg_last;
    end
  end

  assign load    = consume && in_last_r;
  assign rem_out = rem_step;

endmodule

>>> sv/rsenc_obuf.sv
// parity output buffer: holds one codeword's parity and shifts it out
// depends on rsenc_pkg and rsenc_if
module rsenc_obuf
  import rsenc_pkg::*;
#(
  parameter int MAX_PARITY = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  sym_t [MAX_PARITY-1:0]            load_data,
  input  logic [$clog2(MAX_PARITY+1)-1:0]  n_parity,
  output logic                             buf_free,
  rsenc_out_if.source                      out_if
);

  localparam int NW = $clog2(MAX_PARITY + 1);

  logic [NW-1:0]         cnt_r, cnt_nxt;
  sym_t [MAX_PARITY-1:0] par_r, par_nxt;
  sym_t [MAX_PARITY:0]   par_ext;
  logic                  out_acc;

  assign out_acc  = out_if.valid && out_if.ready;
  assign buf_free = (cnt_r == '0) || ((cnt_r == NW'(1)) && out_if.ready);
  assign par_ext  = {SYM_ZERO, par_r};

  // load a fresh remainder or shift out one beat
  always_comb begin
    cnt_nxt = cnt_r;
    par_nxt = par_r;
    priority if (load) begin
      cnt_nxt = n_parity;
      par_nxt = load_data;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int i = 0; i < MAX_PARITY; i++) begin
        par_nxt[i] = par_ext[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    par_r <= par_nxt;
  end

  assign out_if.valid       = (cnt_r != '0);
  assign out_if.parity_byte = par_r[0];
  assign out_if.parity_last = (cnt_r == NW'(1));

endmodule

>>> test/testbench.sv
// self-checking bench for the rs parity encoder: scoreboard class with its own lfsr model,
// plain tasks for the data, parity and parity-count channels
// depends on rsenc_pkg, rsenc_if and reed_solomon_parity_encoder
module testbench;
  import rsenc_pkg::*;

  localparam int PARITY_MAX = 32;
  localparam int SETTLE_CYCLES = 8;

  // one expected parity beat
  typedef struct packed {
    sym_t value;
    logic last;
  } parity_beat_t;

  // lfsr division model and queue of parity beats still owed by the block
  class parity_scoreboard;
    sym_t         gen_poly [PARITY_MAX+1];
    sym_t         rem      [PARITY_MAX];
    int unsigned  n_parity;
    parity_beat_t parity_due [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      set_count(pcount_t'(RESET_PARITY));
    endfunction

    // gf(2^8) product, bits of b from the top down
    function sym_t gf_product(sym_t a, sym_t b);
      sym_t acc;
      acc = SYM_ZERO;
      for (int k = 7; k >= 0; k--) begin
        acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_LOW_POLY : SYM_ZERO);
        if (b[k]) acc = acc ^ a;
      end
      return acc;
    endfunction

    // clamp the count, clear the remainder, rebuild prod (x + alpha^r)
    function void set_count(pcount_t v);
      sym_t root;
      n_parity = (v == 0) ? 1 : ((v > PARITY_MAX) ? PARITY_MAX : v);
      foreach (rem[i]) rem[i] = SYM_ZERO;
      foreach (gen_poly[i]) gen_poly[i] = SYM_ZERO;
      gen_poly[n_parity] = SYM_ONE;
      root = SYM_ONE;
      for (int j = 0; j < n_parity; j++) begin
        root = gf_product(root, ALPHA);
        for (int i = 0; i < n_parity; i++)
          gen_poly[i] = gen_poly[i+1] ^ gf_product(root, gen_poly[i]);
        gen_poly[n_parity] = gf_product(root, gen_poly[n_parity]);
      end
    endfunction

    // one accepted data beat; the last one of a message owes n parity beats
    function void note_byte(sym_t d, logic l);
      sym_t fb;
      parity_beat_t b;
      fb = d ^ rem[0];
      for (int i = 0; i + 1 < n_parity; i++)
        rem[i] = rem[i+1] ^ gf_product(gen_poly[i+1], fb);
      rem[n_parity-1] = gf_product(gen_poly[n_parity], fb);
      if (l) begin
        for (int i = 0; i < n_parity; i++) begin
          b.value = rem[i];
          b.last  = (i + 1 == n_parity);
          parity_due.push_back(b);
        end
        foreach (rem[i]) rem[i] = SYM_ZERO;
      end
    endfunction

    // one accepted parity beat against the oldest owed one
    function void check_beat(sym_t v, logic l);
      parity_beat_t b;
      if (parity_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected parity beat: value %h last %b", v, l);
      end else begin
        b = parity_due.pop_front();
        if (b.value !== v || b.last !== l) begin
          mismatches++;
          if (mismatches <= 10)
            $display("parity mismatch: expected value %h last %b, got value %h last %b",
                     b.value, b.last, v, l);
        end
      end
    endfunction

    function int unsigned pending();
      return parity_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned send_idle;
  int unsigned recv_stall;
  parity_scoreboard board;

  rsenc_in_if  in_ch ();
  rsenc_out_if out_ch ();
  rsenc_cfg_if cfg_ch ();

  reed_solomon_parity_encoder #(
    .MAX_PARITY(PARITY_MAX)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parity sink: check accepted beats, random backpressure
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_beat(out_ch.parity_byte, out_ch.parity_last);
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // one data beat, with random idle cycles ahead of it
  task push_byte(input sym_t d, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.msg_last  <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_byte(d, l);
  endtask

  // parity-count write, only while the block is idle
  task write_count(input pcount_t v);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.parity_count <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_count(v);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait until every owed parity beat is in, then let the pipeline settle
  task drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random messages, mostly short, sometimes a tail left open for the next write
  task run_messages(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int k = 0; k < len; k++)
        push_byte(sym_t'($urandom_range(255)), k == len - 1);
      sent += len;
    end
    if ($urandom_range(3) == 0) begin
      len = $urandom_range(3, 1);
      for (int k = 0; k < len; k++)
        push_byte(sym_t'($urandom_range(255)), 1'b0);
    end
  endtask

  // run timeout
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  // main sequence
  initial begin
    pcount_t pc;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    send_idle           = 0;
    recv_stall          = 0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = SYM_ZERO;
    in_ch.msg_last      = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.parity_count = '0;
    board               = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset count of 16: single-byte messages at the byte extremes, then a short one
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h55, 1'b1);
    drain();

    // count of zero acts as one
    write_count(pcount_t'(0));
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'ha5, 1'b1);
    drain();

    // all-ones count clamps to the maximum
    write_count(pcount_t'(63));
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b1);
    drain();

    // just above the maximum, then the maximum itself
    write_count(pcount_t'(33));
    push_byte(8'h7e, 1'b1);
    drain();
    write_count(pcount_t'(PARITY_MAX));
    push_byte(8'h01, 1'b1);
    drain();

    // write in the middle of a message abandons it
    push_byte(8'hc3, 1'b0);
    push_byte(8'h3c, 1'b0);
    drain();
    write_count(pcount_t'(5));
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);
    drain();
    write_count(pcount_t'(1));
    push_byte(8'h9a, 1'b1);
    drain();

    // random phases over the idle modes and a spread of counts
    for (int p = 0; p < 8; p++) begin
      if (p == 0) pc = pcount_t'(1);
      else if (p == 1) pc = pcount_t'(PARITY_MAX);
      else if (p % 2 == 0) pc = pcount_t'($urandom_range(63));
      else pc = pcount_t'($urandom_range(PARITY_MAX, 1));
      write_count(pc);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 75; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 75; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      run_messages(44);
      drain();
    end

    if (board.mismatches == 0 && board.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
